// ===== design/flash_slot_metadata_scanner_macros.svh =====
// Assertion macros for the flash slot metadata scanner.
`ifndef FLASH_SLOT_METADATA_SCANNER_MACROS_SVH
`define FLASH_SLOT_METADATA_SCANNER_MACROS_SVH

`ifndef NO_ASSERTIONS
`define FSMS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("fsms assertion failed");
`define FSMS_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("fsms assertion failed");
`else
`define FSMS_ASSERT(lbl, clk, rst_n, prop)
`define FSMS_ASSERT_NR(lbl, clk, prop)
`endif

`endif

// ===== design/fsms_pkg.sv =====
// Types and constants shared by the flash slot metadata scanner.
package fsms_pkg;

  localparam int unsigned MAX_SLOT_WORDS_DEF = 65536;

  localparam int unsigned CFG_W     = 19;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [31:0] MAGIC_LO = 32'h47455350;
  localparam logic [31:0] MAGIC_HI = 32'h31454D41;

  localparam int unsigned REL_SIZE    = 2;
  localparam int unsigned REL_HEIGHT  = 3;
  localparam int unsigned REL_SLUG    = 4;
  localparam int unsigned REL_TITLE   = 10;
  localparam int unsigned REL_VERSION = 18;
  localparam int unsigned REL_END     = 21;

  localparam logic [7:0] SLOT_NUM_MAX = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SLOT_BYTES,
    CFG_META_BYTES,
    CFG_ICON_WIDTH,
    CFG_ICON_HEIGHT,
    CFG_ICON_START,
    CFG_ENTRY_LIMIT
  } cfg_idx_t;

  typedef enum logic {
    KIND_TEXT,
    KIND_VERDICT
  } kind_t;

  typedef enum logic [1:0] {
    FIELD_SLUG,
    FIELD_TITLE,
    FIELD_VERSION
  } field_t;

  typedef struct packed {
    kind_t       kind;
    field_t      field_id;
    logic [2:0]  field_word;
    logic [31:0] text_bytes;
    logic [7:0]  slot_number;
    logic        accepted;
    logic        magic_found;
    logic [17:0] block_offset;
    logic [15:0] declared_size;
    logic        icon_ok;
    logic [18:0] icon_offset;
    logic [7:0]  entry_number;
  } result_t;

endpackage

// ===== design/fsms_ifs.sv =====
// Request channel interfaces for flash words in and scan results out.
interface fsms_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] word_data;
  logic        last_in_slot;
  logic        start_of_scan;

  modport source(output valid, word_data, last_in_slot, start_of_scan, input ready);
  modport sink(input valid, word_data, last_in_slot, start_of_scan, output ready);
endinterface

interface fsms_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [1:0]  field_id;
  logic [2:0]  field_word;
  logic [31:0] text_bytes;
  logic [7:0]  slot_number;
  logic        accepted;
  logic        magic_found;
  logic [17:0] block_offset;
  logic [15:0] declared_size;
  logic        icon_ok;
  logic [18:0] icon_offset;
  logic [7:0]  entry_number;

  modport source(output valid, result_kind, field_id, field_word, text_bytes, slot_number,
                 accepted, magic_found, block_offset, declared_size, icon_ok, icon_offset,
                 entry_number, input ready);
  modport sink(input valid, result_kind, field_id, field_word, text_bytes, slot_number,
               accepted, magic_found, block_offset, declared_size, icon_ok, icon_offset,
               entry_number, output ready);
endinterface

// ===== design/flash_slot_metadata_scanner.sv =====
// Flash slot metadata scanner top level: magic search, header checks, field text, verdicts.
// Results of an accepted word are pushed into a three-entry output queue, registered, then offered;
// one result leaves per cycle while the receiver is ready.
// Words are accepted one per cycle while the queue holds at most one result; a word yielding both
// a text word and a verdict queues two. Synchronous active-low reset clears all control state.
`include "flash_slot_metadata_scanner_macros.svh"

module flash_slot_metadata_scanner #(
  parameter int unsigned MAX_SLOT_WORDS = fsms_pkg::MAX_SLOT_WORDS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [fsms_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [fsms_pkg::CFG_W-1:0]     cfg_data,
  fsms_in_if.sink                        in_if,
  fsms_out_if.source                     out_if
);

  localparam int unsigned PW  = $clog2(MAX_SLOT_WORDS + 1);
  localparam int unsigned CW0 = (PW + 2 > 19) ? PW + 2 : 19;
  localparam int unsigned CW  = CW0 + 1;

  logic [18:0] slot_bytes_r;
  logic [15:0] meta_bytes_r;
  logic [15:0] icon_width_r;
  logic [15:0] icon_height_r;
  logic [15:0] icon_start_r;
  logic [7:0]  entry_limit_r;

  logic [PW-1:0] pos_r, pos_nxt;
  logic [PW-1:0] blk_r, blk_nxt;
  logic          first_r, first_nxt;
  logic          found_r, found_nxt;
  logic [15:0]   hsz_r, hsz_nxt;
  logic          wm_r, wm_nxt;
  logic          hm_r, hm_nxt;
  logic          tp_r, tp_nxt;
  logic          nul_r, nul_nxt;
  logic [7:0]    slots_r, slots_nxt;
  logic [7:0]    ents_r, ents_nxt;

  fsms_pkg::result_t q_r [3];
  fsms_pkg::result_t q_nxt [3];
  logic [1:0]        cnt_r, cnt_nxt;

  logic          in_acc;
  logic          pop;
  logic          active;
  logic [7:0]    slot_no;

  logic [PW-1:0] pos_b, blk_b;
  logic          first_b, found_b, wm_b, hm_b, tp_b, nul_b;
  logic [15:0]   hsz_b;
  logic [7:0]    slots_b, ents_b;

  logic [PW-1:0] pos_u, blk_u;
  logic          first_u, found_u, wm_u, hm_u, tp_u, nul_u;
  logic [15:0]   hsz_u;

  logic [PW-1:0] pos_m1;
  logic [PW-1:0] rel;
  logic          mag_fit;
  logic          is_field;
  logic          text_valid;
  logic          verd_valid;
  fsms_pkg::field_t fid;
  logic [2:0]    fw;
  logic          nul_run;
  logic [31:0]   text;
  logic [31:0]   w;

  logic          size_ok, vacc, icon;
  logic [PW+1:0] boff_full;
  logic [7:0]    ents_v;

  fsms_pkg::result_t text_res, verd_res, res0, res1;
  logic [1:0]    push_n;
  logic [1:0]    cnt_pop;

  assign in_acc       = in_if.valid && in_if.ready;
  assign pop          = out_if.valid && out_if.ready;
  assign in_if.ready  = (cnt_r <= 2'd1);
  assign out_if.valid = (cnt_r != 2'd0);
  assign w            = in_if.word_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_bytes_r  <= 19'd262144;
      meta_bytes_r  <= 16'd88;
      icon_width_r  <= 16'd16;
      icon_height_r <= 16'd16;
      icon_start_r  <= 16'd88;
      entry_limit_r <= 8'd255;
    end else if (cfg_we) begin
      unique case (fsms_pkg::cfg_idx_t'(cfg_idx))
        fsms_pkg::CFG_SLOT_BYTES:  slot_bytes_r  <= cfg_data;
        fsms_pkg::CFG_META_BYTES:  meta_bytes_r  <= cfg_data[15:0];
        fsms_pkg::CFG_ICON_WIDTH:  icon_width_r  <= cfg_data[15:0];
        fsms_pkg::CFG_ICON_HEIGHT: icon_height_r <= cfg_data[15:0];
        fsms_pkg::CFG_ICON_START:  icon_start_r  <= cfg_data[15:0];
        fsms_pkg::CFG_ENTRY_LIMIT: entry_limit_r <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (in_if.start_of_scan) begin
      pos_b   = '0;
      blk_b   = '0;
      first_b = 1'b0;
      found_b = 1'b0;
      hsz_b   = '0;
      wm_b    = 1'b0;
      hm_b    = 1'b0;
      tp_b    = 1'b0;
      nul_b   = 1'b0;
      slots_b = '0;
      ents_b  = '0;
    end else begin
      pos_b   = pos_r;
      blk_b   = blk_r;
      first_b = first_r;
      found_b = found_r;
      hsz_b   = hsz_r;
      wm_b    = wm_r;
      hm_b    = hm_r;
      tp_b    = tp_r;
      nul_b   = nul_r;
      slots_b = slots_r;
      ents_b  = ents_r;
    end

    active  = (ents_b < entry_limit_r);
    slot_no = (slots_b == fsms_pkg::SLOT_NUM_MAX) ? fsms_pkg::SLOT_NUM_MAX : slots_b + 8'd1;

    pos_m1  = pos_b - PW'(1);
    mag_fit = (CW'({pos_m1, 2'b00}) + CW'(meta_bytes_r)) <= CW'(slot_bytes_r);
    rel     = pos_b - blk_b;

    pos_u   = pos_b;
    blk_u   = blk_b;
    first_u = first_b;
    found_u = found_b;
    hsz_u   = hsz_b;
    wm_u    = wm_b;
    hm_u    = hm_b;
    tp_u    = tp_b;
    nul_u   = nul_b;

    is_field = 1'b0;
    fid      = fsms_pkg::FIELD_SLUG;
    fw       = '0;
    text     = '0;
    nul_run  = nul_b;

    if (pos_b < PW'(MAX_SLOT_WORDS)) begin
      pos_u = pos_b + PW'(1);
      if (!found_b) begin
        if (first_b && (w == fsms_pkg::MAGIC_HI) && mag_fit) begin
          found_u = 1'b1;
          blk_u   = pos_m1;
        end
        first_u = (w == fsms_pkg::MAGIC_LO);
      end else if (rel == PW'(fsms_pkg::REL_SIZE)) begin
        hsz_u = w[15:0];
        wm_u  = (w[31:16] == icon_width_r);
      end else if (rel == PW'(fsms_pkg::REL_HEIGHT)) begin
        hm_u = (w[15:0] == icon_height_r);
      end else if (rel >= PW'(fsms_pkg::REL_SLUG) && rel <= PW'(fsms_pkg::REL_END)) begin
        is_field = 1'b1;
        if (rel < PW'(fsms_pkg::REL_TITLE)) begin
          fid = fsms_pkg::FIELD_SLUG;
          fw  = 3'(rel - PW'(fsms_pkg::REL_SLUG));
        end else if (rel < PW'(fsms_pkg::REL_VERSION)) begin
          fid = fsms_pkg::FIELD_TITLE;
          fw  = 3'(rel - PW'(fsms_pkg::REL_TITLE));
        end else begin
          fid = fsms_pkg::FIELD_VERSION;
          fw  = 3'(rel - PW'(fsms_pkg::REL_VERSION));
        end
        if (fw == 3'd0) begin
          nul_run = 1'b0;
        end
        if (rel == PW'(fsms_pkg::REL_TITLE)) begin
          tp_u = (w[7:0] != 8'd0);
        end
        for (int b = 0; b < 4; b++) begin
          if (w[8*b +: 8] == 8'd0) begin
            nul_run = 1'b1;
          end
          if (!nul_run) begin
            text[8*b +: 8] = w[8*b +: 8];
          end
        end
        nul_u = nul_run;
      end
    end

    text_valid = is_field && active && (hsz_b >= meta_bytes_r);
    verd_valid = in_if.last_in_slot && active;

    size_ok   = found_u && (hsz_u >= meta_bytes_r);
    vacc      = size_ok && tp_u;
    icon      = size_ok && wm_u && hm_u;
    boff_full = {blk_u, 2'b00};
    ents_v    = ents_b + {7'd0, vacc};

    text_res               = '0;
    text_res.kind          = fsms_pkg::KIND_TEXT;
    text_res.field_id      = fid;
    text_res.field_word    = fw;
    text_res.text_bytes    = text;
    text_res.slot_number   = slot_no;

    verd_res               = '0;
    verd_res.kind          = fsms_pkg::KIND_VERDICT;
    verd_res.field_id      = fsms_pkg::FIELD_SLUG;
    verd_res.slot_number   = slot_no;
    verd_res.accepted      = vacc;
    verd_res.magic_found   = found_u;
    verd_res.block_offset  = found_u ? 18'(boff_full) : 18'd0;
    verd_res.declared_size = found_u ? hsz_u : 16'd0;
    verd_res.icon_ok       = icon;
    verd_res.icon_offset   = icon ? (19'(boff_full) + 19'(icon_start_r)) : 19'd0;
    verd_res.entry_number  = ents_v;

    pos_nxt   = pos_u;
    blk_nxt   = blk_u;
    first_nxt = first_u;
    found_nxt = found_u;
    hsz_nxt   = hsz_u;
    wm_nxt    = wm_u;
    hm_nxt    = hm_u;
    tp_nxt    = tp_u;
    nul_nxt   = nul_u;
    slots_nxt = slots_b;
    ents_nxt  = ents_b;

    if (in_if.last_in_slot) begin
      if (active) begin
        ents_nxt = ents_v;
        if (slots_b != fsms_pkg::SLOT_NUM_MAX) begin
          slots_nxt = slots_b + 8'd1;
        end
      end
      pos_nxt   = '0;
      blk_nxt   = '0;
      first_nxt = 1'b0;
      found_nxt = 1'b0;
      hsz_nxt   = '0;
      wm_nxt    = 1'b0;
      hm_nxt    = 1'b0;
      tp_nxt    = 1'b0;
      nul_nxt   = 1'b0;
    end
  end

  always_comb begin
    res0    = text_valid ? text_res : verd_res;
    res1    = verd_res;
    push_n  = in_acc ? ({1'b0, text_valid} + {1'b0, verd_valid}) : 2'd0;
    cnt_pop = cnt_r - {1'b0, pop};
    for (int i = 0; i < 3; i++) begin
      if (pop && i < 2) begin
        q_nxt[i] = q_r[i+1];
      end else begin
        q_nxt[i] = q_r[i];
      end
      if (push_n != 2'd0 && cnt_pop == 2'(i)) begin
        q_nxt[i] = res0;
      end
      if (push_n == 2'd2 && (cnt_pop + 2'd1) == 2'(i)) begin
        q_nxt[i] = res1;
      end
    end
    cnt_nxt = cnt_pop + push_n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      blk_r   <= '0;
      first_r <= 1'b0;
      found_r <= 1'b0;
      hsz_r   <= '0;
      wm_r    <= 1'b0;
      hm_r    <= 1'b0;
      tp_r    <= 1'b0;
      nul_r   <= 1'b0;
      slots_r <= '0;
      ents_r  <= '0;
      cnt_r   <= '0;
    end else begin
      if (in_acc) begin
        pos_r   <= pos_nxt;
        blk_r   <= blk_nxt;
        first_r <= first_nxt;
        found_r <= found_nxt;
        hsz_r   <= hsz_nxt;
        wm_r    <= wm_nxt;
        hm_r    <= hm_nxt;
        tp_r    <= tp_nxt;
        nul_r   <= nul_nxt;
        slots_r <= slots_nxt;
        ents_r  <= ents_nxt;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign out_if.result_kind   = q_r[0].kind;
  assign out_if.field_id      = q_r[0].field_id;
  assign out_if.field_word    = q_r[0].field_word;
  assign out_if.text_bytes    = q_r[0].text_bytes;
  assign out_if.slot_number   = q_r[0].slot_number;
  assign out_if.accepted      = q_r[0].accepted;
  assign out_if.magic_found   = q_r[0].magic_found;
  assign out_if.block_offset  = q_r[0].block_offset;
  assign out_if.declared_size = q_r[0].declared_size;
  assign out_if.icon_ok       = q_r[0].icon_ok;
  assign out_if.icon_offset   = q_r[0].icon_offset;
  assign out_if.entry_number  = q_r[0].entry_number;

  `FSMS_ASSERT(a_verdict_queued, clk, rst_n, in_acc && in_if.last_in_slot && active |=> out_if.valid)
  `FSMS_ASSERT(a_no_accept_full, clk, rst_n, (cnt_r == 2'd3) |-> !in_acc)
  `FSMS_ASSERT(a_text_clean, clk, rst_n, out_if.valid && out_if.result_kind == fsms_pkg::KIND_TEXT |-> !out_if.accepted && !out_if.magic_found && out_if.entry_number == 8'd0)
  `FSMS_ASSERT_NR(a_reset_empty, clk, !rst_n |=> !out_if.valid)

endmodule

// ===== tb/fsms_scan_checker.sv =====
`timescale 1ns / 100ps
// Scan checker: follows config writes, predicts the scanner results of each flash word, compares.
module fsms_scan_checker #(
  parameter int unsigned MAX_SLOT_WORDS = fsms_pkg::MAX_SLOT_WORDS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [fsms_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [fsms_pkg::CFG_W-1:0]     cfg_data,
  fsms_in_if                             in_ch,
  fsms_out_if                            out_ch,
  output int                             errors,
  output int                             pending
);
  import fsms_pkg::*;

  logic [18:0] slot_bytes;
  logic [15:0] meta_bytes;
  logic [15:0] icon_width;
  logic [15:0] icon_height;
  logic [15:0] icon_start;
  logic [7:0]  entry_limit;

  logic [16:0] word_pos;
  logic [16:0] block_start;
  logic        first_magic;
  logic        block_found;
  logic [15:0] header_size;
  logic        width_match;
  logic        height_match;
  logic        title_present;
  logic        nul_seen;
  logic [7:0]  slots_seen;
  logic [7:0]  entries;

  result_t awaited_results[$];

  task automatic clear_slot();
    word_pos      = '0;
    first_magic   = 1'b0;
    block_found   = 1'b0;
    block_start   = '0;
    header_size   = '0;
    width_match   = 1'b0;
    height_match  = 1'b0;
    title_present = 1'b0;
    nul_seen      = 1'b0;
  endtask

  task automatic apply_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    case (cfg_idx_t'(idx))
      CFG_SLOT_BYTES:  slot_bytes  = data;
      CFG_META_BYTES:  meta_bytes  = data[15:0];
      CFG_ICON_WIDTH:  icon_width  = data[15:0];
      CFG_ICON_HEIGHT: icon_height = data[15:0];
      CFG_ICON_START:  icon_start  = data[15:0];
      CFG_ENTRY_LIMIT: entry_limit = data[7:0];
      default: ;
    endcase
  endtask

  task automatic scan_word(input logic [31:0] w, input logic last, input logic sos);
    logic        active;
    logic [7:0]  slot_no;
    logic [16:0] pos;
    logic [16:0] rel;
    field_t      fid;
    logic [2:0]  fw;
    logic [31:0] text;
    logic        size_ok;
    logic        acc;
    logic        icon;
    logic [17:0] boff;
    logic [18:0] icon_sum;
    result_t     r;
    if (sos) begin
      slots_seen = '0;
      entries    = '0;
      clear_slot();
    end
    active  = entries < entry_limit;
    slot_no = (slots_seen < SLOT_NUM_MAX) ? slots_seen + 8'd1 : SLOT_NUM_MAX;

    if (word_pos < MAX_SLOT_WORDS) begin
      pos      = word_pos;
      word_pos = pos + 17'd1;
      if (!block_found) begin
        if (first_magic && w == MAGIC_HI &&
            (32'(pos) - 32'd1) * 32'd4 + 32'(meta_bytes) <= 32'(slot_bytes)) begin
          block_found = 1'b1;
          block_start = pos - 17'd1;
        end
        first_magic = (w == MAGIC_LO);
      end else begin
        rel = pos - block_start;
        if (rel == REL_SIZE) begin
          header_size = w[15:0];
          width_match = (w[31:16] == icon_width);
        end else if (rel == REL_HEIGHT) begin
          height_match = (w[15:0] == icon_height);
        end else if (rel >= REL_SLUG && rel <= REL_END) begin
          if (rel < REL_TITLE) begin
            fid = FIELD_SLUG;
            fw  = 3'(rel - REL_SLUG);
          end else if (rel < REL_VERSION) begin
            fid = FIELD_TITLE;
            fw  = 3'(rel - REL_TITLE);
          end else begin
            fid = FIELD_VERSION;
            fw  = 3'(rel - REL_VERSION);
          end
          if (fw == 3'd0) nul_seen = 1'b0;
          if (rel == REL_TITLE) title_present = (w[7:0] != 8'h00);
          text = '0;
          for (int i = 0; i < 4; i++) begin
            if (w[8*i +: 8] == 8'h00) nul_seen = 1'b1;
            if (!nul_seen) text[8*i +: 8] = w[8*i +: 8];
          end
          if (active && header_size >= meta_bytes) begin
            r             = '0;
            r.kind        = KIND_TEXT;
            r.field_id    = fid;
            r.field_word  = fw;
            r.text_bytes  = text;
            r.slot_number = slot_no;
            awaited_results.push_back(r);
          end
        end
      end
    end

    if (last) begin
      if (active) begin
        size_ok  = block_found && header_size >= meta_bytes;
        acc      = size_ok && title_present;
        icon     = size_ok && width_match && height_match;
        boff     = block_found ? {block_start[15:0], 2'b00} : '0;
        icon_sum = boff + icon_start;
        if (acc) entries = entries + 8'd1;
        r               = '0;
        r.kind          = KIND_VERDICT;
        r.field_id      = FIELD_SLUG;
        r.slot_number   = slot_no;
        r.accepted      = acc;
        r.magic_found   = block_found;
        r.block_offset  = boff;
        r.declared_size = block_found ? header_size : 16'd0;
        r.icon_ok       = icon;
        r.icon_offset   = icon ? icon_sum : 19'd0;
        r.entry_number  = entries;
        awaited_results.push_back(r);
        if (slots_seen < SLOT_NUM_MAX) slots_seen = slots_seen + 8'd1;
      end
      clear_slot();
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  task automatic check_result();
    result_t exp_r;
    if (awaited_results.size() == 0) begin
      $error("result with no request waiting: kind %0d slot %0d", out_ch.result_kind,
             out_ch.slot_number);
      errors++;
    end else begin
      exp_r = awaited_results.pop_front();
      check_field("result_kind", exp_r.kind, out_ch.result_kind);
      check_field("field_id", exp_r.field_id, out_ch.field_id);
      check_field("field_word", exp_r.field_word, out_ch.field_word);
      check_field("text_bytes", exp_r.text_bytes, out_ch.text_bytes);
      check_field("slot_number", exp_r.slot_number, out_ch.slot_number);
      check_field("accepted", exp_r.accepted, out_ch.accepted);
      check_field("magic_found", exp_r.magic_found, out_ch.magic_found);
      check_field("block_offset", exp_r.block_offset, out_ch.block_offset);
      check_field("declared_size", exp_r.declared_size, out_ch.declared_size);
      check_field("icon_ok", exp_r.icon_ok, out_ch.icon_ok);
      check_field("icon_offset", exp_r.icon_offset, out_ch.icon_offset);
      check_field("entry_number", exp_r.entry_number, out_ch.entry_number);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      slot_bytes  = 19'd262144;
      meta_bytes  = 16'd88;
      icon_width  = 16'd16;
      icon_height = 16'd16;
      icon_start  = 16'd88;
      entry_limit = 8'd255;
      clear_slot();
      slots_seen  = '0;
      entries     = '0;
      awaited_results.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) check_result();
      if (cfg_we) apply_cfg(cfg_idx, cfg_data);
      if (in_ch.valid && in_ch.ready) begin
        scan_word(in_ch.word_data, in_ch.last_in_slot, in_ch.start_of_scan);
      end
    end
    pending <= awaited_results.size();
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Testbench top: streams flash slots and config writes into the scanner and reports the verdict.
module testbench;
  import fsms_pkg::*;

  localparam int unsigned TB_SLOT_WORDS = 40;

  logic                 clk      = 1'b0;
  logic                 rst_n    = 1'b0;
  logic                 cfg_we   = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx  = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  int          errors;
  int          pending;
  bit          calm;
  logic [15:0] cur_meta;
  logic [15:0] cur_width;
  logic [15:0] cur_height;
  logic [31:0] slot_words[$];

  fsms_in_if  in_ch();
  fsms_out_if out_ch();

  flash_slot_metadata_scanner #(
    .MAX_SLOT_WORDS (TB_SLOT_WORDS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .in_if    (in_ch),
    .out_if   (out_ch)
  );

  fsms_scan_checker #(
    .MAX_SLOT_WORDS (TB_SLOT_WORDS)
  ) scan_check (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .errors   (errors),
    .pending  (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= calm || ($urandom_range(99) >= 31);
    end
  end

  initial begin
    #1_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic send_word(input logic [31:0] w, input logic last, input logic sos);
    if (!calm) begin
      while ($urandom_range(99) < 31) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_ch.valid         <= 1'b1;
    in_ch.word_data     <= w;
    in_ch.last_in_slot  <= last;
    in_ch.start_of_scan <= sos;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // hold the sender until every awaited result is back
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input int unsigned val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= CFG_W'(val);
    @(posedge clk);
  endtask

  task automatic configure(input int unsigned sb, input int unsigned meta, input int unsigned iw,
                           input int unsigned ih, input int unsigned ist,
                           input int unsigned lim);
    write_reg(CFG_SLOT_BYTES, sb);
    write_reg(CFG_META_BYTES, meta);
    write_reg(CFG_ICON_WIDTH, iw);
    write_reg(CFG_ICON_HEIGHT, ih);
    write_reg(CFG_ICON_START, ist);
    write_reg(CFG_ENTRY_LIMIT, lim);
    cfg_we     <= 1'b0;
    cur_meta   = meta[15:0];
    cur_width  = iw[15:0];
    cur_height = ih[15:0];
  endtask

  function automatic logic [31:0] noise_word(input bit decoys);
    logic [31:0] w;
    w = $urandom;
    if (decoys) begin
      case ($urandom_range(15))
        0: w = MAGIC_LO;
        1: w = MAGIC_HI;
        default: ;
      endcase
    end
    return w;
  endfunction

  function automatic logic [31:0] text_word();
    logic [31:0] w;
    for (int i = 0; i < 4; i++) begin
      case ($urandom_range(9))
        0: w[8*i +: 8] = 8'h00;
        1: w[8*i +: 8] = 8'($urandom);
        default: w[8*i +: 8] = 8'(8'h20 + $urandom_range(94));
      endcase
    end
    return w;
  endfunction

  task automatic make_slot(input int length, input int magic_at, input logic [15:0] size,
                           input logic [15:0] width, input logic [15:0] height,
                           input bit title_empty, input bit decoys);
    logic [31:0] w;
    slot_words.delete();
    for (int i = 0; i < length; i++) slot_words.push_back(noise_word(decoys));
    if (magic_at >= 0) begin
      for (int k = 0; k <= REL_END && magic_at + k < length; k++) begin
        case (k)
          0: w = MAGIC_LO;
          1: w = MAGIC_HI;
          REL_SIZE: w = {width, size};
          REL_HEIGHT: w = {16'($urandom), height};
          default: begin
            w = text_word();
            if (k == REL_TITLE && title_empty) w[7:0] = 8'h00;
          end
        endcase
        slot_words[magic_at + k] = w;
      end
    end
  endtask

  task automatic send_slot(input bit scan_start, input int sos_at);
    int n;
    n = slot_words.size();
    for (int i = 0; i < n; i++) begin
      send_word(slot_words[i], i == n - 1, (scan_start && i == 0) || i == sos_at);
    end
  endtask

  task automatic random_slot(input int max_at);
    int          magic_at;
    int          length;
    int          sos_at;
    logic [15:0] size;
    logic [15:0] width;
    logic [15:0] height;
    magic_at = ($urandom_range(9) == 0) ? -1 : int'($urandom_range(max_at));
    if (magic_at < 0) length = $urandom_range(1, 30);
    else if ($urandom_range(7) == 0) length = magic_at + $urandom_range(1, 21);
    else length = magic_at + 22 + $urandom_range(3);
    case ($urandom_range(4))
      0: size = cur_meta;
      1: size = cur_meta - 16'd1;
      2: size = 16'hFFFF;
      3: size = 16'($urandom);
      default: size = cur_meta + 16'($urandom_range(64));
    endcase
    width  = ($urandom_range(3) == 0) ? 16'($urandom) : cur_width;
    height = ($urandom_range(3) == 0) ? 16'($urandom) : cur_height;
    make_slot(length, magic_at, size, width, height, $urandom_range(5) == 0, 1'b1);
    sos_at = ($urandom_range(19) == 0) ? int'($urandom_range(length - 1)) : -1;
    send_slot($urandom_range(3) == 0, sos_at);
  endtask

  task automatic run_phase(input int unsigned sb, input int unsigned meta, input int unsigned iw,
                           input int unsigned ih, input int unsigned ist,
                           input int unsigned lim, input int nslots, input int max_at);
    settle();
    configure(sb, meta, iw, ih, ist, lim);
    repeat (nslots) random_slot(max_at);
  endtask

  initial begin
    in_ch.valid         <= 1'b0;
    in_ch.word_data     <= '0;
    in_ch.last_in_slot  <= 1'b0;
    in_ch.start_of_scan <= 1'b0;
    calm       = 1'b0;
    cur_meta   = 16'd88;
    cur_width  = 16'd16;
    cur_height = 16'd16;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    make_slot(22, 0, 16'd88, 16'd16, 16'd16, 1'b0, 1'b0);
    send_slot(1'b1, -1);
    send_word(32'hFFFF_FFFF, 1'b1, 1'b0);
    send_word(32'h0000_0000, 1'b1, 1'b0);

    run_phase(262144, 88, 16, 16, 88, 255, 2, 6);
    run_phase(4, 88, 0, 0, 0, 255, 2, 4);
    run_phase(120, 88, $urandom_range(65535), $urandom_range(65535), $urandom_range(65535),
              3, 2, 10);
    run_phase(262144, 65535, 0, 0, 65535, 2, 2, 6);
    run_phase(262144, 88, 65535, 65535, 0, 0, 1, 6);
    run_phase($urandom_range(1000, 262144), $urandom_range(88, 300), $urandom_range(65535),
              $urandom_range(65535), $urandom_range(65535), 1, 2, 8);
    repeat (2) begin
      run_phase($urandom_range(4, 262144), $urandom_range(88, 65535), $urandom_range(65535),
                $urandom_range(65535), $urandom_range(65535), $urandom_range(255), 2, 8);
    end

    // slot numbers saturate after 255 slots
    settle();
    configure(262144, 88, 16, 16, 88, 255);
    for (int i = 0; i < 260; i++) send_word(noise_word(1'b1), 1'b1, i == 0);

    // long slot: block near the end, words past the word limit ignored
    settle();
    configure(262144, 88, 16, 16, 65535, 255);
    calm = 1'b1;
    make_slot(TB_SLOT_WORDS + 24, TB_SLOT_WORDS - 26, 16'd88, 16'd16, 16'd16,
              1'b0, 1'b0);
    send_slot(1'b1, -1);
    settle();
    calm = 1'b0;

    repeat (8) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== flash_slot_metadata_scanner.f =====
+incdir+design
design/fsms_pkg.sv
design/fsms_ifs.sv
design/flash_slot_metadata_scanner.sv
tb/fsms_scan_checker.sv
tb/testbench.sv
